// ===== rtl/owmq_pkg.sv =====
// ----------------------------------------------------------------------------
// owmq_pkg
// Shared constants, command type and slot helper for the message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package owmq_pkg;

   localparam int Slots      = 8;
   localparam int SlotBytes  = 512;
   localparam int SlotW      = $clog2(Slots);
   localparam int OffW       = $clog2(SlotBytes);
   localparam int LenW       = $clog2(SlotBytes + 1);
   localparam int AddrW      = SlotW + OffW;
   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_READ    = 2'd1,
      OP_DISCARD = 2'd2,
      OP_STATUS  = 2'd3
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [7:0]      data_byte;
      logic            byte_present;
      logic            last;
      logic [OffW-1:0] read_offset;
   } cmd_type;

   function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
      logic [SlotW-1:0] n;
      if (s == SlotW'(Slots - 1)) begin
         n = '0;
      end else begin
         n = s + 1'b1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/owmq_front.sv =====
// ----------------------------------------------------------------------------
// owmq_front
// Takes request items and decodes them into commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module owmq_front import owmq_pkg::*; (
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_func,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_byte_present,
   input  wire logic             req_last,
   input  wire logic [OffW-1:0]  req_read_offset,
   output logic                  push,
   output cmd_type               push_cmd,
   input  wire logic             q_full
);

   op_type op;

   always_comb begin
      unique case (req_func)
         2'd0:    op = OP_APPEND;
         2'd1:    op = OP_READ;
         2'd2:    op = OP_DISCARD;
         default: op = OP_STATUS;
      endcase
   end

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_cmd.op           = op;
      // fields an op does not use are zeroed so the back end never sees stale bits
      push_cmd.data_byte    = (op == OP_APPEND) ? req_data_byte : 8'd0;
      push_cmd.byte_present = (op == OP_APPEND) && req_byte_present;
      push_cmd.last         = (op == OP_APPEND) && req_last;
      push_cmd.read_offset  = (op == OP_READ) ? req_read_offset : '0;
   end

endmodule

`default_nettype wire

// ===== rtl/owmq_queue.sv =====
// ----------------------------------------------------------------------------
// owmq_queue
// Short command queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module owmq_queue import owmq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         q_valid,
   output cmd_type      q_cmd,
   input  wire logic    pop
);

   cmd_type           entry_ff [QueueDepth];
   logic [QPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]  count_ff, count_in;

   function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
      logic [QPtrW-1:0] n;
      if (p == QPtrW'(QueueDepth - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   assign full    = (count_ff == QCntW'(QueueDepth));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/owmq_back.sv =====
// ----------------------------------------------------------------------------
// owmq_back
// Executes commands: slot ring pointers, message build, byte store, results.
// ----------------------------------------------------------------------------
`default_nettype none

module owmq_back import owmq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire cmd_type           q_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_done_res,
   output logic [7:0]             rsp_read_byte,
   output logic [LenW-1:0]        rsp_head_length,
   output logic                   rsp_queue_empty,
   output logic [SlotW-1:0]       rsp_rear_index,
   output logic                   rsp_dropped_oldest,
   output logic                   rsp_rejected_oversize
);

   logic [7:0]       mem [Slots * SlotBytes];
   logic [7:0]       mem_rd_ff;
   logic [LenW-1:0]  lengths_ff [Slots];

   logic [SlotW-1:0] front_ff, front_in;
   logic [SlotW-1:0] rear_ff, rear_in;
   logic [LenW-1:0]  cnt_ff, cnt_in, cnt_after;
   logic             ovf_ff, ovf_in, ovf_after;
   logic [LenW-1:0]  hlen_ff, hlen_in;

   logic             rsp_valid_ff;
   logic             done_ff, hit_ff, dropped_ff, rejected_ff, empty_ff;
   logic [LenW-1:0]  rsp_hlen_ff;
   logic [SlotW-1:0] rsp_rear_ff;

   logic             done, hit, dropped, rejected, commit, mem_we;
   logic [AddrW-1:0] mem_addr;
   logic [SlotW-1:0] target, head_new;
   logic             empty_cur, empty_new;

   assign pop       = q_valid && (!rsp_valid_ff || rsp_ready);
   assign target    = next_slot(rear_ff);
   assign empty_cur = (front_ff == rear_ff);

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      cnt_after = cnt_ff;
      ovf_after = ovf_ff;
      done      = 1'b0;
      hit       = 1'b0;
      dropped   = 1'b0;
      rejected  = 1'b0;
      commit    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = {target, cnt_ff[OffW-1:0]};
      if (pop) begin
         unique case (q_cmd.op)
            OP_APPEND: begin
               if (q_cmd.byte_present) begin
                  if (cnt_ff < LenW'(SlotBytes)) begin
                     mem_we    = 1'b1;
                     cnt_after = cnt_ff + 1'b1;
                  end else begin
                     ovf_after = 1'b1;
                  end
               end
               cnt_in = cnt_after;
               ovf_in = ovf_after;
               if (q_cmd.last) begin
                  if (ovf_after) begin
                     rejected = 1'b1;
                  end else begin
                     commit  = 1'b1;
                     rear_in = target;
                     done    = 1'b1;
                     // ring full after commit: oldest message becomes the sentinel
                     if (next_slot(target) == front_ff) begin
                        front_in = next_slot(front_ff);
                        dropped  = 1'b1;
                     end
                  end
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
            OP_READ: begin
               mem_addr = {next_slot(front_ff), q_cmd.read_offset};
               if (!empty_cur) begin
                  done = 1'b1;
                  hit  = ({1'b0, q_cmd.read_offset} < hlen_ff);
               end
            end
            OP_DISCARD: begin
               if (!empty_cur) begin
                  front_in = next_slot(front_ff);
                  done     = 1'b1;
               end
            end
            OP_STATUS: begin
            end
         endcase
      end
      head_new  = next_slot(front_in);
      empty_new = (front_in == rear_in);
      // length of a message committed this cycle is forwarded past the table
      if (empty_new) begin
         hlen_in = '0;
      end else if (commit && (head_new == target)) begin
         hlen_in = cnt_after;
      end else begin
         hlen_in = lengths_ff[head_new];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         hlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         if (pop) begin
            hlen_ff <= hlen_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         done_ff     <= done;
         hit_ff      <= hit;
         dropped_ff  <= dropped;
         rejected_ff <= rejected;
         empty_ff    <= empty_new;
         rsp_hlen_ff <= hlen_in;
         rsp_rear_ff <= rear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         lengths_ff[target] <= cnt_after;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= q_cmd.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mem_rd_ff <= mem[mem_addr];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_done_res          = done_ff;
   assign rsp_read_byte         = hit_ff ? mem_rd_ff : 8'd0;
   assign rsp_head_length       = rsp_hlen_ff;
   assign rsp_queue_empty       = empty_ff;
   assign rsp_rear_index        = rsp_rear_ff;
   assign rsp_dropped_oldest    = dropped_ff;
   assign rsp_rejected_oversize = rejected_ff;

endmodule

`default_nettype wire

// ===== rtl/overwrite_oldest_message_queue_core.sv =====
// ----------------------------------------------------------------------------
// overwrite_oldest_message_queue_core
// Ring of message slots that drops the oldest message when it fills.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_ready  func, data_byte, byte_present,
//                                            last, read_offset
//  rsp_      out        rsp_valid/rsp_ready  done_res, read_byte, head_length,
//                                            queue_empty, rear_index,
//                                            dropped_oldest, rejected_oversize
//
//  one item per cycle sustained while the receiver keeps rsp_ready high; an
//  item passes the command queue, then its result registers load on the pop
//  while a result waits the two-entry queue takes two more items, then ready
//  drops; ready follows the queue count
//  synchronous reset empties the ring and the build; the byte store and the
//  length table are not cleared, the stored lengths bound every read
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_oldest_message_queue_core import owmq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_func,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_byte_present,
   input  wire logic              req_last,
   input  wire logic [8:0]        req_read_offset,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_done_res,
   output logic [7:0]             rsp_read_byte,
   output logic [9:0]             rsp_head_length,
   output logic                   rsp_queue_empty,
   output logic [2:0]             rsp_rear_index,
   output logic                   rsp_dropped_oldest,
   output logic                   rsp_rejected_oversize
);

   logic    push, q_full, q_valid, pop;
   cmd_type push_cmd, q_cmd;

   owmq_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .req_read_offset  (req_read_offset),
      .push             (push),
      .push_cmd         (push_cmd),
      .q_full           (q_full)
   );

   owmq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .pop      (pop)
   );

   owmq_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_cmd                 (q_cmd),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_done_res          (rsp_done_res),
      .rsp_read_byte         (rsp_read_byte),
      .rsp_head_length       (rsp_head_length),
      .rsp_queue_empty       (rsp_queue_empty),
      .rsp_rear_index        (rsp_rear_index),
      .rsp_dropped_oldest    (rsp_dropped_oldest),
      .rsp_rejected_oversize (rsp_rejected_oversize)
   );

   // a rejected message never counts as committed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_rejected_oversize))
      else $error("rejected message reported as done");

   // dropping the oldest only happens on a commit that leaves messages queued
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped_oldest |-> rsp_done_res && !rsp_queue_empty)
      else $error("drop without commit or on empty ring");

   // an empty ring reports no head length and no read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_head_length == 10'd0 && rsp_read_byte == 8'd0)
      else $error("empty ring reports head data");

   // the back end only takes a command the queue holds
   assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("command taken from empty queue");

endmodule

`default_nettype wire

// ===== bench/owmq_report_checker.sv =====
// ----------------------------------------------------------------------------
// owmq_report_checker
// Watches both channels of the message queue core, keeps its own copy of the
// ring, the slot contents and the message under construction, and checks
// every result against the report predicted for the oldest taken item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owmq_report_checker import owmq_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire logic [1:0]      req_func,
   input  wire logic [7:0]      req_data_byte,
   input  wire logic            req_byte_present,
   input  wire logic            req_last,
   input  wire logic [OffW-1:0] req_read_offset,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire logic            rsp_done_res,
   input  wire logic [7:0]      rsp_read_byte,
   input  wire logic [LenW-1:0] rsp_head_length,
   input  wire logic            rsp_queue_empty,
   input  wire logic [SlotW-1:0] rsp_rear_index,
   input  wire logic            rsp_dropped_oldest,
   input  wire logic            rsp_rejected_oversize,
   output int                   mismatch_count,
   output int                   reports_pending
);

   typedef struct packed {
      logic            done;
      logic [7:0]      rbyte;
      logic [LenW-1:0] hlen;
      logic            empty;
      logic [SlotW-1:0] rear;
      logic            dropped;
      logic            rejected;
   } queue_report_type;

   logic [SlotW-1:0] front_q;
   logic [SlotW-1:0] rear_q;
   logic [7:0]       slot_data [Slots][SlotBytes];
   logic [LenW-1:0]  slot_len [Slots];
   logic [LenW-1:0]  build_len;
   logic             build_over;
   queue_report_type pending_reports [$];

   function automatic logic [SlotW-1:0] ring_after(input logic [SlotW-1:0] s);
      return (s == SlotW'(Slots - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic string format_report(input queue_report_type r);
      return $sformatf("done=%0d byte=%02h len=%0d empty=%0d rear=%0d drop=%0d rej=%0d",
                       r.done, r.rbyte, r.hlen, r.empty, r.rear, r.dropped, r.rejected);
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic advance_queue_model(input op_type op, input logic [7:0] data,
                                      input logic present, input logic last,
                                      input logic [OffW-1:0] offset,
                                      output queue_report_type rep);
      logic [SlotW-1:0] target;
      logic [SlotW-1:0] head;
      rep = '0;
      case (op)
         OP_APPEND: begin
            // the message under construction lives in the slot past rear
            target = ring_after(rear_q);
            if (present) begin
               if (build_len < LenW'(SlotBytes)) begin
                  slot_data[target][build_len[OffW-1:0]] = data;
                  build_len = build_len + 1'b1;
               end else begin
                  build_over = 1'b1;
               end
            end
            if (last) begin
               if (build_over) begin
                  rep.rejected = 1'b1;
               end else begin
                  rear_q = target;
                  slot_len[target] = build_len;
                  rep.done = 1'b1;
                  // front is a sentinel, so the ring is full one slot early
                  if (ring_after(rear_q) == front_q) begin
                     front_q = ring_after(front_q);
                     rep.dropped = 1'b1;
                  end
               end
               build_len  = '0;
               build_over = 1'b0;
            end
         end
         OP_READ: begin
            if (front_q != rear_q) begin
               head = ring_after(front_q);
               rep.done = 1'b1;
               if (LenW'(offset) < slot_len[head]) begin
                  rep.rbyte = slot_data[head][offset];
               end
            end
         end
         OP_DISCARD: begin
            if (front_q != rear_q) begin
               front_q = ring_after(front_q);
               rep.done = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rep.empty = (front_q == rear_q);
      rep.hlen  = rep.empty ? '0 : slot_len[ring_after(front_q)];
      rep.rear  = rear_q;
   endtask

   always @(posedge clock) begin
      queue_report_type predicted;
      queue_report_type observed;
      queue_report_type oldest;
      if (reset) begin
         front_q        = '0;
         rear_q         = '0;
         build_len      = '0;
         build_over     = 1'b0;
         mismatch_count = 0;
         for (int s = 0; s < Slots; s++) begin
            slot_len[s] = '0;
         end
         pending_reports.delete();
      end else begin
         if (req_valid && req_ready) begin
            advance_queue_model(op_type'(req_func), req_data_byte, req_byte_present,
                                req_last, req_read_offset, predicted);
            pending_reports.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            observed.done     = rsp_done_res;
            observed.rbyte    = rsp_read_byte;
            observed.hlen     = rsp_head_length;
            observed.empty    = rsp_queue_empty;
            observed.rear     = rsp_rear_index;
            observed.dropped  = rsp_dropped_oldest;
            observed.rejected = rsp_rejected_oversize;
            if (pending_reports.size() == 0) begin
               note_failure({"result with no item waiting: ", format_report(observed)});
            end else begin
               oldest = pending_reports.pop_front();
               if (observed !== oldest) begin
                  note_failure({"expected ", format_report(oldest),
                                " got ", format_report(observed)});
               end
            end
         end
      end
      reports_pending = pending_reports.size();
   end

endmodule

// ===== bench/overwrite_oldest_message_queue_core_test.sv =====
// ----------------------------------------------------------------------------
// overwrite_oldest_message_queue_core_test
// Drives the message queue core with directed corner items and then random
// message streams mixed with reads, discards and noise, under bursty input
// and a stalling receiver; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module overwrite_oldest_message_queue_core_test;
   import owmq_pkg::*;

   localparam int RandomItems = 1550;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_func = OP_STATUS;
   logic [7:0]        req_data_byte = '0;
   logic              req_byte_present = 1'b0;
   logic              req_last = 1'b0;
   logic [OffW-1:0]   req_read_offset = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_done_res;
   logic [7:0]        rsp_read_byte;
   logic [LenW-1:0]   rsp_head_length;
   logic              rsp_queue_empty;
   logic [SlotW-1:0]  rsp_rear_index;
   logic              rsp_dropped_oldest;
   logic              rsp_rejected_oversize;
   int                mismatch_count;
   int                reports_pending;

   int burst_left = 0;
   int items_sent = 0;

   overwrite_oldest_message_queue_core DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_data_byte         (req_data_byte),
      .req_byte_present      (req_byte_present),
      .req_last              (req_last),
      .req_read_offset       (req_read_offset),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_done_res          (rsp_done_res),
      .rsp_read_byte         (rsp_read_byte),
      .rsp_head_length       (rsp_head_length),
      .rsp_queue_empty       (rsp_queue_empty),
      .rsp_rear_index        (rsp_rear_index),
      .rsp_dropped_oldest    (rsp_dropped_oldest),
      .rsp_rejected_oversize (rsp_rejected_oversize)
   );

   owmq_report_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_data_byte         (req_data_byte),
      .req_byte_present      (req_byte_present),
      .req_last              (req_last),
      .req_read_offset       (req_read_offset),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_done_res          (rsp_done_res),
      .rsp_read_byte         (rsp_read_byte),
      .rsp_head_length       (rsp_head_length),
      .rsp_queue_empty       (rsp_queue_empty),
      .rsp_rear_index        (rsp_rear_index),
      .rsp_dropped_oldest    (rsp_dropped_oldest),
      .rsp_rejected_oversize (rsp_rejected_oversize),
      .mismatch_count        (mismatch_count),
      .reports_pending       (reports_pending)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // entered and left at a falling edge; gaps only fall between bursts
   task automatic push_item(input op_type op, input logic [7:0] data,
                            input logic present, input logic last,
                            input logic [OffW-1:0] offset);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        = 1'b1;
      req_func         = op;
      req_data_byte    = data;
      req_byte_present = present;
      req_last         = last;
      req_read_offset  = offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // non-append item; the append fields carry junk
   task automatic push_command(input op_type op, input logic [OffW-1:0] offset);
      push_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), offset);
   endtask

   task automatic send_message(input int len, input bit interleave, input bit late_commit);
      for (int i = 0; i < len; i++) begin
         if (interleave && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: push_command(OP_READ, OffW'($urandom_range(0, 511)));
               1: push_command(OP_DISCARD, OffW'($urandom_range(0, 511)));
               2: push_command(OP_STATUS, OffW'($urandom_range(0, 511)));
               default: begin
                  push_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                            OffW'($urandom_range(0, 511)));
               end
            endcase
         end
         push_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b1,
                   (i == len - 1) && !late_commit, OffW'($urandom_range(0, 511)));
      end
      if (len == 0 || late_commit) begin
         push_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b0, 1'b1,
                   OffW'($urandom_range(0, 511)));
      end
   endtask

   // receiver: random stalls, then one long hold-off, then a mix of patterns
   initial begin
      int         mode;
      int         phase;
      logic [7:0] stall_mask;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (150) begin
         @(negedge clock);
         rsp_ready = 1'($urandom_range(0, 1));
      end
      @(negedge clock);
      rsp_ready = 1'b0;
      repeat (300) @(negedge clock);
      forever begin
         mode       = $urandom_range(0, 3);
         stall_mask = 8'($urandom_range(1, 255));
         phase      = 0;
         repeat ($urandom_range(20, 80)) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 3) != 0);
               2: rsp_ready = ($urandom_range(0, 3) == 0);
               default: begin
                  rsp_ready = stall_mask[phase % 8];
                  phase++;
               end
            endcase
         end
      end
   end

   initial begin
      int directed_end;
      int pick;
      int len;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty queue: status, read and discard find nothing
      push_command(OP_STATUS, '0);
      push_command(OP_READ, '0);
      push_command(OP_DISCARD, '0);
      // empty message, then a three byte message with extreme bytes
      push_item(OP_APPEND, 8'h5A, 1'b0, 1'b1, '1);
      push_item(OP_APPEND, 8'h00, 1'b1, 1'b0, '0);
      push_item(OP_APPEND, 8'hFF, 1'b1, 1'b0, '1);
      push_item(OP_APPEND, 8'hA5, 1'b1, 1'b1, '0);
      push_command(OP_READ, '0);
      push_command(OP_DISCARD, '0);
      push_command(OP_READ, '0);
      push_command(OP_READ, OffW'(2));
      push_command(OP_READ, OffW'(3));
      push_command(OP_READ, '1);
      // overfill the ring so the oldest messages get dropped
      for (int k = 0; k < 7; k++) begin
         push_item(OP_APPEND, 8'(k + 1), 1'b1, 1'b1, '0);
      end
      // reads and discards in the middle of a build
      push_item(OP_APPEND, 8'h3C, 1'b1, 1'b0, '1);
      push_command(OP_READ, OffW'(1));
      push_command(OP_DISCARD, '0);
      push_item(OP_APPEND, 8'hC3, 1'b1, 1'b1, '0);
      directed_end = items_sent;

      // drain the ring, then a full size message and an oversize one
      repeat (Slots - 1) push_command(OP_DISCARD, OffW'($urandom_range(0, 511)));
      send_message(SlotBytes, 1'b0, 1'($urandom_range(0, 1)));
      repeat (8) push_command(OP_READ, OffW'($urandom_range(0, 511)));
      push_command(OP_READ, OffW'(SlotBytes - 1));
      send_message(SlotBytes + 1 + $urandom_range(0, 2), 1'b1, 1'($urandom_range(0, 1)));
      push_command(OP_READ, OffW'($urandom_range(0, 511)));

      while (items_sent < directed_end + RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            case ($urandom_range(0, 9))
               0: len = 0;
               1: len = $urandom_range(9, 40);
               default: len = $urandom_range(1, 8);
            endcase
            send_message(len, 1'b1, ($urandom_range(0, 3) == 0));
         end else if (pick < 75) begin
            if ($urandom_range(0, 9) < 7) begin
               push_command(OP_READ, OffW'($urandom_range(0, 15)));
            end else begin
               push_command(OP_READ, OffW'($urandom_range(0, 511)));
            end
         end else if (pick < 85) begin
            push_command(OP_DISCARD, OffW'($urandom_range(0, 511)));
         end else if (pick < 90) begin
            push_command(OP_STATUS, OffW'($urandom_range(0, 511)));
         end else begin
            push_item(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      OffW'($urandom_range(0, 511)));
         end
      end

      req_valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== overwrite_oldest_message_queue_core.f =====
rtl/owmq_pkg.sv
rtl/owmq_front.sv
rtl/owmq_queue.sv
rtl/owmq_back.sv
rtl/overwrite_oldest_message_queue_core.sv
bench/owmq_report_checker.sv
bench/overwrite_oldest_message_queue_core_test.sv
